// File: rtl/pcs_pkg.sv
package pcs_pkg;

    typedef struct packed {
        logic [31:0]        parent_visits;
        logic [31:0]        child_visits;
        logic signed [47:0] child_value_sum;
        logic [16:0]        prior;
        logic               last_child;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         best_index;
        logic signed [47:0] win_score;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_MUL,
        ST_QDIV,
        ST_TDIV,
        ST_UPDATE,
        ST_FINISH
    } back_state_t;

    localparam logic signed [47:0] SCORE_MIN = 48'sh8000_0000_0000;
    localparam logic signed [47:0] SCORE_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic [15:0]        CFG_RESET = 16'd4096;

endpackage

// File: rtl/puct_child_select.sv
// Children are handled one at a time: the first child of a group starts the 32-step square
// root of the parent visits; then come a product, a division of the value sum by the visits
// (skipped when the child has no visits) and a division for the exploration term, both
// 48-step on one shared divider. A two-entry queue takes transfers while a child is in work.
// Reset: asynchronous, active low; clears the queue, the group state and the output
// valid flag, and sets the exploration constant to 1.0.
module puct_child_select #(
    parameter int MAX_CHILDREN = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  pcs_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output pcs_pkg::out_item_t out_item,
    input  logic               cfg_write_en,
    input  logic [15:0]        cfg_write_data
);

    logic [15:0]       cfg_reg;
    logic              q_valid;
    logic              pop;
    pcs_pkg::in_item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= pcs_pkg::CFG_RESET;
        end
        else if (cfg_write_en)
        begin
            cfg_reg <= cfg_write_data;
        end
    end

    pcs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_item   (q_item)
    );

    pcs_back #(
        .MAX_CHILDREN (MAX_CHILDREN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .expl_c    (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// File: rtl/pcs_front.sv
module pcs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  pcs_pkg::in_item_t in_item,
    input  logic              pop,
    output logic              q_valid,
    output pcs_pkg::in_item_t q_item
);

    pcs_pkg::in_item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: rtl/pcs_div.sv
module pcs_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);

    logic [32:0] rem_reg, rem_next;
    logic [47:0] quo_reg, quo_next;
    logic [32:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [33:0] trial;
    logic [33:0] diff;
    logic        ge;

    assign trial    = {rem_reg, quo_reg[47]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = 33'd0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = 6'd47;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[32:0] : trial[32:0];
            quo_next = {quo_reg[46:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

// File: rtl/pcs_sqrt.sv
module pcs_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] count,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] x_reg, x_next;
    logic [34:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [34:0] r;
    logic [34:0] trial;

    assign r     = {rem_reg[32:0], x_reg[63:62]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign done  = done_reg;
    assign root  = root_reg;

    always_comb
    begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = {count, 32'd0};
            rem_next  = 35'd0;
            root_next = 32'd0;
            cnt_next  = 5'd31;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = {x_reg[61:0], 2'b00};
            if (r >= trial)
            begin
                rem_next  = r - trial;
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = r;
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

endmodule

// File: rtl/pcs_back.sv
module pcs_back #(
    parameter int MAX_CHILDREN = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        expl_c,
    input  logic               q_valid,
    input  pcs_pkg::in_item_t  q_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output pcs_pkg::out_item_t out_item
);

    localparam int LIMIT = (MAX_CHILDREN > 256) ? 256 : MAX_CHILDREN;

    pcs_pkg::back_state_t state_reg, state_next;
    pcs_pkg::in_item_t    item_reg;
    pcs_pkg::out_item_t   out_reg;
    logic [20:0]          cp_reg;
    logic [31:0]          root_reg;
    logic [52:0]          num_reg;
    logic signed [48:0]   q_reg;
    logic [47:0]          term_reg;
    logic signed [47:0]   lead_score_reg;
    logic [7:0]           best_idx_reg;
    logic [8:0]           pos_reg;
    logic                 open_reg;
    logic                 out_full_reg;

    logic                 sqrt_start, sqrt_done;
    logic [31:0]          sqrt_root;
    logic                 div_start, div_done;
    logic [47:0]          div_dividend, div_quot;
    logic [32:0]          div_divisor;
    logic [32:0]          prod_cp;
    logic [47:0]          w_abs;
    logic signed [48:0]   q_val;
    logic signed [49:0]   diff;
    logic signed [47:0]   score;
    logic                 n_zero;

    assign pop       = (state_reg == pcs_pkg::ST_IDLE) && q_valid;
    assign out_valid = out_full_reg;
    assign out_item  = out_reg;
    assign n_zero    = (item_reg.child_visits == 32'd0);
    assign prod_cp   = expl_c * q_item.prior;
    assign w_abs     = item_reg.child_value_sum[47] ? (48'd0 - item_reg.child_value_sum)
                                                    : item_reg.child_value_sum;
    assign q_val     = item_reg.child_value_sum[47] ? (49'sd0 - signed'({1'b0, div_quot}))
                                                    : signed'({1'b0, div_quot});
    assign diff      = signed'({2'b00, term_reg}) - 50'(q_reg);

    always_comb
    begin
        if (diff > 50'(pcs_pkg::SCORE_MAX))
        begin
            score = pcs_pkg::SCORE_MAX;
        end
        else if (diff < 50'(pcs_pkg::SCORE_MIN))
        begin
            score = pcs_pkg::SCORE_MIN;
        end
        else
        begin
            score = diff[47:0];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        sqrt_start   = 1'b0;
        div_start    = 1'b0;
        div_dividend = w_abs;
        div_divisor  = {1'b0, item_reg.child_visits};
        case (state_reg)
            pcs_pkg::ST_IDLE:
            begin
                if (pop)
                begin
                    sqrt_start = !open_reg;
                    state_next = open_reg ? pcs_pkg::ST_MUL : pcs_pkg::ST_ROOT;
                end
            end
            pcs_pkg::ST_ROOT:
            begin
                if (sqrt_done)
                begin
                    state_next = pcs_pkg::ST_MUL;
                end
            end
            pcs_pkg::ST_MUL:
            begin
                if (pos_reg < 9'(LIMIT))
                begin
                    div_start  = !n_zero;
                    state_next = pcs_pkg::ST_QDIV;
                end
                else
                begin
                    state_next = pcs_pkg::ST_FINISH;
                end
            end
            pcs_pkg::ST_QDIV:
            begin
                if (n_zero || div_done)
                begin
                    div_start    = 1'b1;
                    div_dividend = {11'd0, num_reg[52:16]};
                    div_divisor  = {1'b0, item_reg.child_visits} + 33'd1;
                    state_next   = pcs_pkg::ST_TDIV;
                end
            end
            pcs_pkg::ST_TDIV:
            begin
                if (div_done)
                begin
                    state_next = pcs_pkg::ST_UPDATE;
                end
            end
            pcs_pkg::ST_UPDATE:
            begin
                state_next = pcs_pkg::ST_FINISH;
            end
            pcs_pkg::ST_FINISH:
            begin
                if (!(item_reg.last_child && out_full_reg))
                begin
                    state_next = pcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pcs_pkg::ST_IDLE;
            open_reg       <= 1'b0;
            out_full_reg   <= 1'b0;
            pos_reg        <= 9'd0;
            best_idx_reg   <= 8'd0;
            lead_score_reg <= pcs_pkg::SCORE_MIN;
            root_reg       <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_full_reg && !out_stall)
            begin
                out_full_reg <= 1'b0;
            end
            if (state_reg == pcs_pkg::ST_ROOT && sqrt_done)
            begin
                root_reg       <= sqrt_root;
                lead_score_reg <= pcs_pkg::SCORE_MIN;
                best_idx_reg   <= 8'd0;
                pos_reg        <= 9'd0;
                open_reg       <= 1'b1;
            end
            if (state_reg == pcs_pkg::ST_UPDATE)
            begin
                if (score > lead_score_reg)
                begin
                    lead_score_reg <= score;
                    best_idx_reg   <= pos_reg[7:0];
                end
                pos_reg <= pos_reg + 9'd1;
            end
            if (state_reg == pcs_pkg::ST_FINISH && item_reg.last_child && !out_full_reg)
            begin
                out_full_reg <= 1'b1;
                open_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= q_item;
            cp_reg   <= prod_cp[32:12];
        end
        if (state_reg == pcs_pkg::ST_MUL)
        begin
            num_reg <= cp_reg * root_reg;
        end
        if (state_reg == pcs_pkg::ST_QDIV)
        begin
            q_reg <= n_zero ? 49'sd0 : q_val;
        end
        if (state_reg == pcs_pkg::ST_TDIV && div_done)
        begin
            term_reg <= div_quot;
        end
        if (state_reg == pcs_pkg::ST_FINISH && item_reg.last_child && !out_full_reg)
        begin
            out_reg.best_index <= best_idx_reg;
            out_reg.win_score  <= lead_score_reg;
        end
    end

    pcs_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .count (q_item.parent_visits),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    pcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

endmodule

// File: rtl/pcs_checker.sv
module pcs_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input pcs_pkg::out_item_t out_item
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_item))
        else $error("result changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("input stall rose without a transfer");

    a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("results delivered back to back");

endmodule

bind puct_child_select pcs_checker u_pcs_checker (.*);
